// ===== rtl/core/modexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants and the command bundle for the bit-serial modular multiplier.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // Width of the serial operand register (the unreduced base is this wide).
  localparam int unsigned OPER_W = 32;

  // Width of the bit count handed to the multiplier (holds OPER_W itself).
  localparam int unsigned LEN_W = 6;

  // Modulus after reset.
  localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

  // Command to one multiplier: a start strobe and the number of serial bits.
  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;
  } mm_cmd_t;

endpackage

// ===== rtl/core/modexp_mulmod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Interleaved shift-and-add multiplication: one bit of x per cycle, MSB first,
// with the partial result kept below the modulus after every step.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
  parameter int unsigned MOD_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  modexp_pkg::mm_cmd_t             cmd_i,
  input  logic [modexp_pkg::OPER_W-1:0]   x_i,
  input  logic [MOD_BITS-1:0]             y_i,
  input  logic [MOD_BITS-1:0]             mod_i,
  output logic                            done_o,
  output logic [MOD_BITS-1:0]             res_o
);

  localparam int unsigned OW = modexp_pkg::OPER_W;
  localparam int unsigned LW = modexp_pkg::LEN_W;
  // Two guard bits for 2r + y < 3m, one more for the borrow.
  localparam int unsigned SW = MOD_BITS + 3;

  logic                busy_q;
  logic                done_q;
  logic [LW-1:0]       cnt_q;
  logic [OW-1:0]       x_q;
  logic [MOD_BITS-1:0] y_q;
  logic [MOD_BITS-1:0] r_q;
  logic [MOD_BITS-1:0] r_d;
  logic [SW-1:0]       sum;
  logic [SW-1:0]       diff1;
  logic [SW-1:0]       diff2;
  logic [SW-1:0]       m_ext;

  // One step: r = 2r + bit*y, then subtract 2m if that leaves it non-negative,
  // else m if that does, else nothing. Both differences are formed side by side.
  always_comb begin
    m_ext = SW'(mod_i);
    sum   = (SW'(r_q) << 1) + (x_q[OW-1] ? SW'(y_q) : '0);
    diff1 = sum - m_ext;
    diff2 = sum - (m_ext << 1);
    if (!diff2[SW-1]) begin
      r_d = diff2[MOD_BITS-1:0];
    end else if (!diff1[SW-1]) begin
      r_d = diff1[MOD_BITS-1:0];
    end else begin
      r_d = sum[MOD_BITS-1:0];
    end
  end

  // Sequencing: count down the serial bits and flag the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.len;
      end else if (busy_q) begin
        cnt_q <= cnt_q - LW'(1);
        if (cnt_q == LW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q <= x_i;
      y_q <= y_i;
      r_q <= '0;
    end else if (busy_q) begin
      x_q <= x_q << 1;
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

// ===== rtl/core/modular_exponentiation_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation, right-to-left square and multiply
// Returns base_value ** exponent mod modulus using two bit-serial multipliers.
// ----------------------------------------------------------------------------
//  Channel  | Signals                                    | Direction
//  ---------+--------------------------------------------+----------
//  input    | in_valid_i, in_ready_o, base_value_i,      | in
//           | exponent_i                                 |
//  output   | out_valid_o, out_ready_i, power_result_o   | out
//  config   | psel, penable, pwrite, paddr, pwdata,      | in/out
//           | prdata, pready (modulus at addresses 0-3)  |
//
// For each item the base is first reduced in one pass of the operand width
// through unit A; then each exponent bit up to the highest set one costs one
// pass of MOD_BITS bits through both multipliers, started in the step state
// and taken in the wait state.
// The multiply and the square of one bit run at once on two units.
// A modulus below two gives 0.
// Reset is asynchronous and active low; the modulus returns to 1000000007.
// A new beat is taken while a finished result still waits in the output
// register; a stalled output only holds the next result in its last state.
// ----------------------------------------------------------------------------
module modular_exponentiation_top #(
  parameter int unsigned EXP_BITS = 63,
  parameter int unsigned MOD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] base_value_i,
  input  logic [62:0] exponent_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] power_result_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned OW = modexp_pkg::OPER_W;
  localparam int unsigned LW = modexp_pkg::LEN_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [EXP_BITS-1:0] e_q, e_d;
  logic [MOD_BITS-1:0] acc_q, acc_d;
  logic [MOD_BITS-1:0] b_q, b_d;
  logic [MOD_BITS-1:0] modulus_q;
  logic                out_valid_q, out_valid_d;
  logic [31:0]         out_q, out_d;

  logic                   in_fire;
  logic                   mod_ok;
  logic                   cfg_wr;
  logic [EXP_BITS+62:0]   exp_ext;
  logic [OW-1:0]          b_aligned;
  modexp_pkg::mm_cmd_t    cmd_a, cmd_b;
  logic [OW-1:0]          x_a;
  logic [MOD_BITS-1:0]    y_a;
  logic                   a_done, b_done;
  logic [MOD_BITS-1:0]    a_res, b_res;

  // Configuration register: one word, the modulus.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0 : 32'(modulus_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MOD_BITS'(modexp_pkg::MODULUS_RESET);
    end else if (cfg_wr) begin
      modulus_q <= pwdata[MOD_BITS-1:0];
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign mod_ok     = (modulus_q > MOD_BITS'(1));
  assign exp_ext    = {{EXP_BITS{1'b0}}, exponent_i};
  assign b_aligned  = OW'(b_q) << (OW - MOD_BITS);

  // Multiplier operands: unit A reduces the base first, then forms acc * b;
  // unit B squares b.
  always_comb begin
    cmd_a.start = 1'b0;
    cmd_a.len   = LW'(MOD_BITS);
    cmd_b.start = 1'b0;
    cmd_b.len   = LW'(MOD_BITS);
    x_a         = b_aligned;
    y_a         = acc_q;
    if (state_q == S_IDLE) begin
      cmd_a.start = in_fire && mod_ok;
      cmd_a.len   = LW'(OW);
      x_a         = base_value_i;
      y_a         = MOD_BITS'(1);
    end else if (state_q == S_STEP) begin
      cmd_a.start = (e_q != '0);
      cmd_b.start = (e_q != '0);
    end
  end

  modexp_mulmod #(
    .MOD_BITS(MOD_BITS)
  ) u_mul_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_a),
    .x_i    (x_a),
    .y_i    (y_a),
    .mod_i  (modulus_q),
    .done_o (a_done),
    .res_o  (a_res)
  );

  modexp_mulmod #(
    .MOD_BITS(MOD_BITS)
  ) u_mul_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_b),
    .x_i    (b_aligned),
    .y_i    (b_q),
    .mod_i  (modulus_q),
    .done_o (b_done),
    .res_o  (b_res)
  );

  // Sequencer: reduce the base, then one square-and-multiply pass per exponent bit
  // until no set bit is left; a modulus below two goes straight to a result of 0.
  always_comb begin
    state_d     = state_q;
    e_d         = e_q;
    acc_d       = acc_q;
    b_d         = b_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          e_d = exp_ext[EXP_BITS-1:0];
          if (mod_ok) begin
            state_d = S_RED;
          end else begin
            acc_d   = '0;
            state_d = S_FIN;
          end
        end
      end
      S_RED: begin
        if (a_done) begin
          b_d     = a_res;
          acc_d   = MOD_BITS'(1);
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (e_q == '0) begin
          state_d = S_FIN;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (a_done) begin
          if (e_q[0]) begin
            acc_d = a_res;
          end
          b_d     = b_res;
          e_d     = e_q >> 1;
          state_d = S_STEP;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = 32'(acc_q);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    e_q   <= e_d;
    acc_q <= acc_d;
    b_q   <= b_d;
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign power_result_o = out_q;

  // The two multipliers always finish in the same cycle of a pass.
  a_units_in_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) |-> (a_done == b_done))
    else $error("multipliers out of step");

  // A clear exponent bit leaves the accumulator alone.
  a_acc_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT && a_done && !e_q[0]) |=> (acc_q == $past(acc_q)))
    else $error("accumulator changed on a clear exponent bit");

  // A result only appears on leaving the final state.
  a_result_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("result raised outside the final state");

  // A multiplier never reports completion while the block is idle or in the final state.
  a_no_stray_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_FIN) |-> !(a_done || b_done))
    else $error("stray multiplier completion");

endmodule
